// ===== hw/rtl/ics_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ics_pkg
// Shared types and codes for the IMU calibration sequencer.
// ============================================================================
package ics_pkg;

    typedef enum logic [2:0] {
        FUNC_TICK        = 3'd0,
        FUNC_SAVE        = 3'd1,
        FUNC_ABORT       = 3'd2,
        FUNC_START_GYRO  = 3'd3,
        FUNC_START_ACCEL = 3'd4
    } func_t;

    localparam logic [1:0] REG_GYRO_TARGET = 2'd0;
    localparam logic [1:0] REG_SETTLE      = 2'd1;
    localparam logic [1:0] REG_WINDOW_END  = 2'd2;

    localparam logic [2:0] PHASE_IDLE   = 3'd0;
    localparam logic [2:0] PHASE_GYRO   = 3'd1;
    localparam logic [2:0] PHASE_ACCEL1 = 3'd2;
    localparam logic [2:0] PHASE_ACCEL6 = 3'd7;

    localparam logic [15:0] GYRO_TARGET_RST = 16'd2000;
    localparam logic [15:0] SETTLE_RST      = 16'd2000;
    localparam logic [15:0] WINDOW_END_RST  = 16'd5000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] time_ms;
        logic        orientation_ok;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } in_item_t;

    typedef struct packed {
        logic        record_valid;
        logic [2:0]  recorded_step;
        logic signed [15:0] avg_x;
        logic signed [15:0] avg_y;
        logic signed [15:0] avg_z;
        logic [2:0]  phase_now;
        logic        save_rejected;
        logic        sequence_done;
    } out_item_t;

    // Work handed from the front to the back.
    typedef struct packed {
        logic        emit;
        logic        use_gyro;   // set when the sums are gyro sums (else accel sums)
        logic [2:0]  step;
        logic [2:0]  phase_now;
        logic        save_rejected;
        logic        sequence_done;
        logic [31:0] sum0;
        logic [31:0] sum1;
        logic [31:0] sum2;
        logic [31:0] count;
    } job_t;

endpackage

// ===== hw/rtl/ics_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ics_if
// Valid/ready channel interfaces for items, results and register writes.
// ============================================================================
interface ics_in_if;
    import ics_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ics_out_if;
    import ics_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ics_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/ics_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ics_front
// Accepts commands and samples, keeps sequence state and sums, and issues jobs.
// ============================================================================
module ics_front
    import ics_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    input  logic [15:0] gyro_target,
    input  logic [15:0] settle,
    input  logic [15:0] window_end,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    logic [2:0]  phase_reg, phase_next;
    logic        collecting_reg, collecting_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] sums_reg [6];
    logic [31:0] sums_next [6];
    logic [31:0] total_reg, total_next;
    job_t        job_next;
    logic [31:0] smp [6];
    logic [31:0] dt;
    logic [31:0] tot_inc;
    logic        fire;

    assign in_ready = job_ready;
    assign job_valid = in_valid;
    assign fire = in_valid && in_ready;
    assign job = job_next;

    always_comb
    begin
        smp[0] = {{16{in_data.accel_x[15]}}, in_data.accel_x};
        smp[1] = {{16{in_data.accel_y[15]}}, in_data.accel_y};
        smp[2] = {{16{in_data.accel_z[15]}}, in_data.accel_z};
        smp[3] = {{16{in_data.gyro_x[15]}}, in_data.gyro_x};
        smp[4] = {{16{in_data.gyro_y[15]}}, in_data.gyro_y};
        smp[5] = {{16{in_data.gyro_z[15]}}, in_data.gyro_z};
        dt = in_data.time_ms - stamp_reg;
        tot_inc = total_reg + 32'd1;
        phase_next = phase_reg;
        collecting_next = collecting_reg;
        stamp_next = stamp_reg;
        total_next = total_reg;
        for (int i = 0; i < 6; i++)
        begin
            sums_next[i] = sums_reg[i];
        end
        job_next = '0;
        case (in_data.func)
            FUNC_TICK:
            begin
                if (phase_reg == PHASE_GYRO)
                begin
                    if (collecting_reg)
                    begin
                        for (int i = 3; i < 6; i++)
                        begin
                            sums_next[i] = sums_reg[i] + smp[i];
                        end
                        total_next = tot_inc;
                        if (tot_inc >= {16'd0, gyro_target})
                        begin
                            job_next.emit = 1'b1;
                            job_next.use_gyro = 1'b1;
                            job_next.step = 3'd0;
                            job_next.sum0 = sums_next[3];
                            job_next.sum1 = sums_next[4];
                            job_next.sum2 = sums_next[5];
                            job_next.count = tot_inc;
                            job_next.sequence_done = 1'b1;
                            collecting_next = 1'b0;
                            for (int i = 0; i < 6; i++)
                            begin
                                sums_next[i] = '0;
                            end
                            total_next = '0;
                            phase_next = PHASE_IDLE;
                        end
                    end
                end
                else if (phase_reg >= PHASE_ACCEL1 && collecting_reg)
                begin
                    if (dt >= {16'd0, settle} && dt < {16'd0, window_end})
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            sums_next[i] = sums_reg[i] + smp[i];
                        end
                        total_next = tot_inc;
                    end
                    else if (dt >= {16'd0, window_end})
                    begin
                        job_next.emit = 1'b1;
                        job_next.step = phase_reg - 3'd1;
                        job_next.sum0 = sums_reg[0];
                        job_next.sum1 = sums_reg[1];
                        job_next.sum2 = sums_reg[2];
                        job_next.count = total_reg;
                        collecting_next = 1'b0;
                        for (int i = 0; i < 6; i++)
                        begin
                            sums_next[i] = '0;
                        end
                        total_next = '0;
                        if (phase_reg == PHASE_ACCEL6)
                        begin
                            phase_next = PHASE_IDLE;
                            job_next.sequence_done = 1'b1;
                        end
                        else
                        begin
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                end
            end
            FUNC_SAVE:
            begin
                if (phase_reg >= PHASE_ACCEL1)
                begin
                    if (!in_data.orientation_ok)
                    begin
                        job_next.save_rejected = 1'b1;
                    end
                    else
                    begin
                        stamp_next = in_data.time_ms;
                        collecting_next = 1'b1;
                        for (int i = 0; i < 6; i++)
                        begin
                            sums_next[i] = '0;
                        end
                        total_next = '0;
                    end
                end
            end
            FUNC_ABORT:
            begin
                phase_next = PHASE_IDLE;
                collecting_next = 1'b0;
            end
            FUNC_START_GYRO, FUNC_START_ACCEL:
            begin
                phase_next = (in_data.func == FUNC_START_GYRO) ? PHASE_GYRO : PHASE_ACCEL1;
                collecting_next = (in_data.func == FUNC_START_GYRO);
                for (int i = 0; i < 6; i++)
                begin
                    sums_next[i] = '0;
                end
                total_next = '0;
            end
            default:
            begin
            end
        endcase
        job_next.phase_now = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_IDLE;
            collecting_reg <= 1'b0;
            stamp_reg <= '0;
            total_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            collecting_reg <= collecting_next;
            stamp_reg <= stamp_next;
            total_reg <= total_next;
            for (int i = 0; i < 6; i++)
            begin
                sums_reg[i] <= sums_next[i];
            end
        end
    end
endmodule

// ===== hw/rtl/ics_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ics_queue
// Two-entry job queue between the front and the back.
// ============================================================================
module ics_queue
    import ics_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);
    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_fire, rd_fire;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rptr_reg];
    assign wr_fire = wr_valid && wr_ready;
    assign rd_fire = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_fire)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_fire)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (wr_fire && !rd_fire)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (rd_fire && !wr_fire)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule

// ===== hw/rtl/ics_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ics_back
// Divides the three sums by the count with one shared restoring divider.
// ============================================================================
module ics_back
    import ics_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } st_t;

    st_t         st_reg;
    job_t        job_reg;
    logic [1:0]  axis_reg;
    logic [5:0]  bit_reg;
    logic [31:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] div_reg;
    logic        neg_reg;
    logic [15:0] res_reg [3];
    out_item_t   out_reg;
    logic [31:0] cur_sum;
    logic [31:0] mag;
    logic [32:0] trial;
    logic [32:0] shifted;
    logic [31:0] qn;
    logic [15:0] sat;

    assign job_ready = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_data = out_reg;

    always_comb
    begin
        case (axis_reg)
            2'd0: cur_sum = job_reg.sum0;
            2'd1: cur_sum = job_reg.sum1;
            default: cur_sum = job_reg.sum2;
        endcase
        mag = cur_sum[31] ? (32'd0 - cur_sum) : cur_sum;
        shifted = {rem_reg[31:0], quo_reg[31]};
        trial = shifted - {1'b0, div_reg};
        // Signed quotient magnitude, then truncate toward zero and clamp.
        qn = neg_reg ? (32'd0 - quo_reg) : quo_reg;
        if (!neg_reg && quo_reg > 32'd32767)
        begin
            sat = 16'h7FFF;
        end
        else if (neg_reg && quo_reg > 32'd32768)
        begin
            sat = 16'h8000;
        end
        else
        begin
            sat = qn[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg <= job;
                    axis_reg <= 2'd0;
                    div_reg <= (job.count == 32'd0) ? 32'd1 : job.count;
                end
            end
            ST_LOAD:
            begin
                quo_reg <= mag;
                rem_reg <= '0;
                neg_reg <= cur_sum[31];
                bit_reg <= 6'd0;
            end
            ST_DIV:
            begin
                if (bit_reg == 6'd32)
                begin
                    res_reg[axis_reg] <= sat;
                    axis_reg <= axis_reg + 2'd1;
                end
                else
                begin
                    bit_reg <= bit_reg + 6'd1;
                    if (!trial[32])
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= shifted;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            out_reg <= '0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (job.emit)
                        begin
                            st_reg <= ST_LOAD;
                        end
                        else
                        begin
                            out_reg <= '{record_valid: 1'b0, recorded_step: 3'd0,
                                         avg_x: 16'sd0, avg_y: 16'sd0, avg_z: 16'sd0,
                                         phase_now: job.phase_now,
                                         save_rejected: job.save_rejected,
                                         sequence_done: job.sequence_done};
                            st_reg <= ST_OUT;
                        end
                    end
                end
                ST_LOAD:
                begin
                    st_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (bit_reg == 6'd32)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            out_reg <= '{record_valid: 1'b1, recorded_step: job_reg.step,
                                         avg_x: res_reg[0], avg_y: res_reg[1], avg_z: sat,
                                         phase_now: job_reg.phase_now,
                                         save_rejected: job_reg.save_rejected,
                                         sequence_done: job_reg.sequence_done};
                            st_reg <= ST_OUT;
                        end
                        else
                        begin
                            st_reg <= ST_LOAD;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        st_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/imu_calibration_sequencer_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// imu_calibration_sequencer_core
// Gyro bias and six-step accelerometer calibration sequencer.
// ============================================================================
// Usage: each input beat on in_ch is a command or sample tick with a time stamp
// and raw six-axis samples. The block returns exactly one result beat on
// out_ch for every input beat, in order. Register writes arrive on cfg_ch
// (index 0 gyro sample target, 1 settle time, 2 window end) and are taken at
// once; write them only while the block is idle.
// The front stage updates phase, time stamp and running sums in the cycle a
// beat is accepted and pushes a job into a two-entry queue. The back stage
// turns a job into a result: a job with no record is written to the output
// register when the back stage takes it from the queue. A record runs a
// shared 32-step restoring divider three times, once per axis, and the back
// stage takes no new job until its result has been taken. Input beats keep
// being accepted while the queue has room, so the front and back stall
// independently. A stalled receiver holds the result in the output register
// until it is taken. Reset clears phase, sums, queue and the output, and
// restores the register defaults.
// ============================================================================
module imu_calibration_sequencer_core
    import ics_pkg::*;
(
    input logic clk,
    input logic rst_n,
    ics_in_if.sink   in_ch,
    ics_out_if.source out_ch,
    ics_cfg_if.sink  cfg_ch
);
    logic [15:0] gyro_target_reg;
    logic [15:0] settle_reg;
    logic [15:0] window_end_reg;
    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    job_t        fj, bj;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_target_reg <= GYRO_TARGET_RST;
            settle_reg <= SETTLE_RST;
            window_end_reg <= WINDOW_END_RST;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_GYRO_TARGET: gyro_target_reg <= cfg_ch.wdata;
                REG_SETTLE:      settle_reg <= cfg_ch.wdata;
                REG_WINDOW_END:  window_end_reg <= cfg_ch.wdata;
                default:
                begin
                end
            endcase
        end
    end

    ics_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .gyro_target(gyro_target_reg), .settle(settle_reg),
        .window_end(window_end_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    ics_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    ics_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
    );
endmodule

// ===== hw/rtl/ics_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ics_checker
// Port-level checks on the calibration sequencer results.
// ============================================================================
module ics_checker
    import ics_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.record_valid |->
        out_data.avg_x == 16'sd0 && out_data.avg_y == 16'sd0 && out_data.avg_z == 16'sd0)
        else $error("averages set without record");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sequence_done |->
        out_data.phase_now == PHASE_IDLE && out_data.record_valid)
        else $error("done without record or idle phase");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.save_rejected |->
        !out_data.record_valid && out_data.phase_now >= PHASE_ACCEL1)
        else $error("rejection outside accel step");
endmodule

bind imu_calibration_sequencer_core ics_checker u_ics_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
